FILE: sv/dfs_pkg.sv
// Shared types and constants for the depth-first search timestamp block.
package dfs_pkg;

  localparam int MAX_NODES = 64;
  localparam int VTX_W     = $clog2(MAX_NODES);
  localparam int CNT_W     = VTX_W + 1;
  localparam int TIME_W    = 8;
  localparam int PAR_W     = 7;
  localparam int STK_W     = CNT_W + VTX_W;
  localparam int DP_W      = TIME_W + PAR_W;

  localparam logic [PAR_W-1:0]     NO_PARENT = {PAR_W{1'b1}};
  localparam logic [MAX_NODES-1:0] ROW_ONE   = MAX_NODES'(1);
  localparam logic [CNT_W-1:0]     NODES_MAX = CNT_W'(MAX_NODES);

  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_EDGE  = 2'd1,
    MODE_RUN   = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  // Result of one step of the shared index scan unit.
  typedef struct packed {
    logic             done;
    logic             hit;
    logic [CNT_W-1:0] nxt;
  } scan_res_t;

endpackage

FILE: sv/dfs_ram.sv
// Generic single write port RAM with a registered read port.
module dfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/dfs_scan.sv
// Shared scan unit: tests one candidate index against a limit and a candidate mask.
module dfs_scan (
  input  logic [dfs_pkg::CNT_W-1:0]     idx,
  input  logic [dfs_pkg::CNT_W-1:0]     limit,
  input  logic [dfs_pkg::MAX_NODES-1:0] cand,
  output dfs_pkg::scan_res_t            res
);
  import dfs_pkg::*;

  // The limit never exceeds the node count, so an index below it fits the vertex width.
  always_comb begin
    res.done = (idx >= limit);
    res.hit  = !res.done && cand[idx[VTX_W-1:0]];
    res.nxt  = idx + CNT_W'(1);
  end

endmodule

FILE: sv/dfs_discovery_finish_times.sv
// Top level of the depth-first search timestamp block over an adjacency bit matrix.
//
// Usage: an input beat is taken on a rising edge with start high and busy low.
// in_mode selects the operation: clear the matrix, add the undirected edge
// in_node_a / in_node_b, or run a search over vertices 0 to node_count-1.
// A clear never raises busy. An edge keeps busy high while it reads and
// rewrites both matrix rows. A run keeps busy high while the search walks the
// graph: one candidate neighbor per cycle in its scan state through the shared
// scan unit, plus, for each vertex, steps to try it as a root, fetch its row,
// end its scan, return to its parent and read its stored times. At the end the
// run reads the stores of each vertex in turn and streams one result beat per
// cycle, in vertex order, on out_valid; the first beat follows the read of
// vertex zero through the store read register and the output register, and
// the final one carries out_last.
// The receiver cannot stall: each beat is on the ports for one cycle only.
// The node_count register (cfg_we / cfg_wdata) is to be written only while
// idle; the block itself does not enforce this. Values above the vertex
// capacity act as the capacity and zero makes a run do nothing.
// Reset (rst_n low, synchronous) empties the matrix through per-row valid
// bits, restores node_count to its full value and drops any pending beats.
module dfs_discovery_finish_times (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_mode,
  input  logic [dfs_pkg::VTX_W-1:0]     in_node_a,
  input  logic [dfs_pkg::VTX_W-1:0]     in_node_b,
  input  logic                          cfg_we,
  input  logic [dfs_pkg::CNT_W-1:0]     cfg_wdata,
  output logic                          out_valid,
  output logic [dfs_pkg::VTX_W-1:0]     out_vertex,
  output logic [dfs_pkg::TIME_W-1:0]    out_discover_time,
  output logic [dfs_pkg::TIME_W-1:0]    out_finish_time,
  output logic signed [dfs_pkg::PAR_W-1:0] out_parent_vertex,
  output logic                          out_last
);
  import dfs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EDGE_RD,
    S_EDGE_WR,
    S_ROOT,
    S_WAIT,
    S_SCAN,
    S_POP,
    S_OUT
  } state_t;

  state_t state_r, state_nxt;

  // Control state.
  logic [CNT_W-1:0]     node_count_r, node_count_nxt;
  logic [MAX_NODES-1:0] adj_vld_r, adj_vld_nxt;
  logic [CNT_W-1:0]     sp_r, sp_nxt;
  logic [TIME_W-1:0]    time_r, time_nxt;
  logic                 rd_pend_r, rd_pend_nxt;
  logic                 out_valid_r, out_valid_nxt;

  // Working registers of the search and of the edge update.
  logic [VTX_W-1:0]     a_r, a_nxt;
  logic [VTX_W-1:0]     b_r, b_nxt;
  logic                 second_r, second_nxt;
  logic [CNT_W-1:0]     n_r, n_nxt;
  logic [MAX_NODES-1:0] white_r, white_nxt;
  logic [CNT_W-1:0]     r_r, r_nxt;
  logic [VTX_W-1:0]     cur_u_r, cur_u_nxt;
  logic [CNT_W-1:0]     cur_j_r, cur_j_nxt;
  logic [VTX_W-1:0]     v_r, v_nxt;
  logic [VTX_W-1:0]     rd_v_r, rd_v_nxt;
  logic                 rd_last_r, rd_last_nxt;
  logic                 rd_vld_r;

  // Output registers.
  logic [VTX_W-1:0]     out_vertex_r, out_vertex_nxt;
  logic [TIME_W-1:0]    out_disc_r, out_disc_nxt;
  logic [TIME_W-1:0]    out_fin_r, out_fin_nxt;
  logic [PAR_W-1:0]     out_par_r, out_par_nxt;
  logic                 out_last_r, out_last_nxt;

  // Memory ports.
  logic                 adj_we;
  logic [VTX_W-1:0]     adj_waddr, adj_raddr;
  logic [MAX_NODES-1:0] adj_wdata, adj_rdata;
  logic                 stk_we;
  logic [VTX_W-1:0]     stk_waddr, stk_raddr;
  logic [STK_W-1:0]     stk_wdata, stk_rdata;
  logic                 dp_we;
  logic [VTX_W-1:0]     dp_waddr;
  logic [DP_W-1:0]      dp_wdata, dp_rdata;
  logic                 fin_we;
  logic [VTX_W-1:0]     fin_waddr;
  logic [TIME_W-1:0]    fin_wdata, fin_rdata;

  // Scan unit hookup.
  logic [CNT_W-1:0]     scan_idx;
  logic [MAX_NODES-1:0] scan_cand;
  scan_res_t            scan;

  logic [MAX_NODES-1:0] row_eff;
  logic [CNT_W-1:0]     n_eff;
  logic [TIME_W-1:0]    time_inc;
  logic [CNT_W-1:0]     sp_m1, sp_m2;
  mode_t                mode;

  assign mode      = mode_t'(in_mode);
  assign n_eff     = (node_count_r > NODES_MAX) ? NODES_MAX : node_count_r;
  // A row that was never written since the last clear reads as empty.
  assign row_eff   = rd_vld_r ? adj_rdata : '0;
  assign time_inc  = time_r + TIME_W'(1);
  assign sp_m1     = sp_r - CNT_W'(1);
  assign sp_m2     = sp_r - CNT_W'(2);
  // Entries below the top of the walk live in memory; the top is held in cur_u / cur_j.
  assign stk_raddr = sp_m2[VTX_W-1:0];
  assign adj_raddr = (state_r == S_EDGE_RD) ? (second_r ? b_r : a_r) : cur_u_r;

  // Root search scans the unvisited set; neighbor search scans the row of the top vertex.
  assign scan_idx  = (state_r == S_ROOT) ? r_r : cur_j_r;
  assign scan_cand = (state_r == S_ROOT) ? white_r : (row_eff & white_r);

  dfs_scan u_scan (
    .idx   (scan_idx),
    .limit (n_r),
    .cand  (scan_cand),
    .res   (scan)
  );

  dfs_ram #(.WIDTH(MAX_NODES), .DEPTH(MAX_NODES)) u_adj_ram (
    .clk   (clk),
    .we    (adj_we),
    .waddr (adj_waddr),
    .wdata (adj_wdata),
    .raddr (adj_raddr),
    .rdata (adj_rdata)
  );

  dfs_ram #(.WIDTH(STK_W), .DEPTH(MAX_NODES)) u_stk_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  dfs_ram #(.WIDTH(DP_W), .DEPTH(MAX_NODES)) u_dp_ram (
    .clk   (clk),
    .we    (dp_we),
    .waddr (dp_waddr),
    .wdata (dp_wdata),
    .raddr (v_r),
    .rdata (dp_rdata)
  );

  dfs_ram #(.WIDTH(TIME_W), .DEPTH(MAX_NODES)) u_fin_ram (
    .clk   (clk),
    .we    (fin_we),
    .waddr (fin_waddr),
    .wdata (fin_wdata),
    .raddr (v_r),
    .rdata (fin_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    node_count_nxt = cfg_we ? cfg_wdata : node_count_r;
    adj_vld_nxt    = adj_vld_r;
    sp_nxt         = sp_r;
    time_nxt       = time_r;
    rd_pend_nxt    = 1'b0;
    a_nxt          = a_r;
    b_nxt          = b_r;
    second_nxt     = second_r;
    n_nxt          = n_r;
    white_nxt      = white_r;
    r_nxt          = r_r;
    cur_u_nxt      = cur_u_r;
    cur_j_nxt      = cur_j_r;
    v_nxt          = v_r;
    rd_v_nxt       = rd_v_r;
    rd_last_nxt    = rd_last_r;

    adj_we    = 1'b0;
    adj_waddr = second_r ? b_r : a_r;
    adj_wdata = row_eff | (ROW_ONE << (second_r ? a_r : b_r));
    stk_we    = 1'b0;
    stk_waddr = sp_m1[VTX_W-1:0];
    stk_wdata = {scan.nxt, cur_u_r};
    dp_we     = 1'b0;
    dp_waddr  = scan_idx[VTX_W-1:0];
    dp_wdata  = {time_inc, NO_PARENT};
    fin_we    = 1'b0;
    fin_waddr = cur_u_r;
    fin_wdata = time_inc;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          unique case (mode)
            MODE_CLEAR: begin
              adj_vld_nxt = '0;
            end
            MODE_EDGE: begin
              a_nxt      = in_node_a;
              b_nxt      = in_node_b;
              second_nxt = 1'b0;
              state_nxt  = S_EDGE_RD;
            end
            MODE_RUN: begin
              if (n_eff != '0) begin
                n_nxt     = n_eff;
                white_nxt = '1;
                time_nxt  = '0;
                sp_nxt    = '0;
                r_nxt     = '0;
                state_nxt = S_ROOT;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_EDGE_RD: begin
        state_nxt = S_EDGE_WR;
      end
      S_EDGE_WR: begin
        adj_we                 = 1'b1;
        adj_vld_nxt[adj_waddr] = 1'b1;
        if (second_r) begin
          state_nxt = S_IDLE;
        end else begin
          second_nxt = 1'b1;
          state_nxt  = S_EDGE_RD;
        end
      end
      S_ROOT: begin
        if (scan.done) begin
          v_nxt     = '0;
          state_nxt = S_OUT;
        end else if (scan.hit) begin
          time_nxt                        = time_inc;
          dp_we                           = 1'b1;
          white_nxt[scan_idx[VTX_W-1:0]]  = 1'b0;
          cur_u_nxt                       = scan_idx[VTX_W-1:0];
          cur_j_nxt                       = '0;
          sp_nxt                          = CNT_W'(1);
          state_nxt                       = S_WAIT;
        end else begin
          r_nxt = scan.nxt;
        end
      end
      S_WAIT: begin
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (scan.done) begin
          time_nxt  = time_inc;
          fin_we    = 1'b1;
          sp_nxt    = sp_m1;
          state_nxt = (sp_r == CNT_W'(1)) ? S_ROOT : S_POP;
        end else if (scan.hit) begin
          stk_we                          = 1'b1;
          sp_nxt                          = sp_r + CNT_W'(1);
          time_nxt                        = time_inc;
          dp_we                           = 1'b1;
          dp_wdata                        = {time_inc, 1'b0, cur_u_r};
          white_nxt[scan_idx[VTX_W-1:0]]  = 1'b0;
          cur_u_nxt                       = scan_idx[VTX_W-1:0];
          cur_j_nxt                       = '0;
          state_nxt                       = S_WAIT;
        end else begin
          cur_j_nxt = scan.nxt;
        end
      end
      S_POP: begin
        cur_u_nxt = stk_rdata[VTX_W-1:0];
        cur_j_nxt = stk_rdata[STK_W-1:VTX_W];
        state_nxt = S_WAIT;
      end
      S_OUT: begin
        rd_pend_nxt = 1'b1;
        rd_v_nxt    = v_r;
        rd_last_nxt = ({1'b0, v_r} + CNT_W'(1)) == n_r;
        if (rd_last_nxt) begin
          state_nxt = S_IDLE;
        end else begin
          v_nxt = v_r + VTX_W'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Result stage: the stores were read in the previous cycle for the vertex now held in rd_v_r.
    out_valid_nxt  = rd_pend_r;
    out_vertex_nxt = rd_v_r;
    out_disc_nxt   = dp_rdata[DP_W-1:PAR_W];
    out_par_nxt    = dp_rdata[PAR_W-1:0];
    out_fin_nxt    = fin_rdata;
    out_last_nxt   = rd_last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      node_count_r <= NODES_MAX;
      adj_vld_r    <= '0;
      sp_r         <= '0;
      time_r       <= '0;
      rd_pend_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      node_count_r <= node_count_nxt;
      adj_vld_r    <= adj_vld_nxt;
      sp_r         <= sp_nxt;
      time_r       <= time_nxt;
      rd_pend_r    <= rd_pend_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    a_r          <= a_nxt;
    b_r          <= b_nxt;
    second_r     <= second_nxt;
    n_r          <= n_nxt;
    white_r      <= white_nxt;
    r_r          <= r_nxt;
    cur_u_r      <= cur_u_nxt;
    cur_j_r      <= cur_j_nxt;
    v_r          <= v_nxt;
    rd_v_r       <= rd_v_nxt;
    rd_last_r    <= rd_last_nxt;
    rd_vld_r     <= adj_vld_r[adj_raddr];
    out_vertex_r <= out_vertex_nxt;
    out_disc_r   <= out_disc_nxt;
    out_fin_r    <= out_fin_nxt;
    out_par_r    <= out_par_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign busy              = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_vertex        = out_vertex_r;
  assign out_discover_time = out_disc_r;
  assign out_finish_time   = out_fin_r;
  assign out_parent_vertex = $signed(out_par_r);
  assign out_last          = out_last_r;

  // The walk never holds more vertices than the block can take part.
  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= NODES_MAX)
    else $error("walk depth beyond vertex capacity");

  // The vertex being explored has always left the unvisited set.
  a_top_visited: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> !white_r[cur_u_r])
    else $error("top of walk still marked unvisited");

  // The final beat of a run closes the burst.
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |=> !out_valid)
    else $error("result beat after the final beat");

  // An accepted edge beat keeps the block busy for its row updates.
  a_edge_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_mode == MODE_EDGE)) |=> busy)
    else $error("edge update did not hold busy");

endmodule
